>>> sv/bmg_pkg.sv
// Package for the Box-Muller Gaussian pair generator: word types, formats and constants.
package bmg_pkg;

  localparam int unsigned UNIFORM_BITS    = 16;
  localparam int unsigned GAUSS_FRAC_BITS = 12;
  localparam int unsigned GAUSS_BITS      = 16;

  // Pipeline geometry.
  localparam int unsigned SQ_STEPS   = 32;  // log2 squaring steps
  localparam int unsigned SQRT_BITS  = 30;  // root bits, one per stage
  localparam int unsigned TAY_STEPS  = 6;   // Horner steps of each series

  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;

  localparam logic [7:0] SIN_DIV [TAY_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [TAY_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  // floor(2^32 / d), so that y / d is (y * recip) >> 32 with one upward correction.
  localparam logic [31:0] SIN_RECIP [TAY_STEPS] = '{
    32'((64'd1 << 32) / 156), 32'((64'd1 << 32) / 110), 32'((64'd1 << 32) / 72),
    32'((64'd1 << 32) / 42),  32'((64'd1 << 32) / 20),  32'((64'd1 << 32) / 6)};
  localparam logic [31:0] COS_RECIP [TAY_STEPS] = '{
    32'((64'd1 << 32) / 132), 32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 56),
    32'((64'd1 << 32) / 30),  32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2)};

  typedef struct packed {
    logic [UNIFORM_BITS-1:0] uniform_radius;
    logic [UNIFORM_BITS-1:0] uniform_angle;
  } bmg_in_t;

  typedef struct packed {
    logic signed [GAUSS_BITS-1:0] gauss_cos;
    logic signed [GAUSS_BITS-1:0] gauss_sin;
  } bmg_out_t;

endpackage

>>> sv/box_muller_gaussian_pair.sv
// Box-Muller Gaussian pair generator: fully pipelined radius and angle datapaths.
// Throughput: one input word per cycle; busy_o is always low, so words may arrive back to back.
// The depth is set by the 32 log2 squaring stages and the 30 one-bit square root stages.
// The receiver cannot stall; results are strobed for exactly one cycle on result_valid_o.
// Reset clears only the valid pipeline; datapath registers are not reset.
module box_muller_gaussian_pair import bmg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  bmg_in_t  word_i,
  output logic     result_valid_o,
  output bmg_out_t result_o
);

  // Stage indexes. The radius path sets the overall depth; the angle path
  // finishes early and its trig values ride a delay line up to the radius.
  localparam int unsigned R_L        = SQ_STEPS + 1;
  localparam int unsigned R_W        = SQ_STEPS + 2;
  localparam int unsigned PIPE_LAST  = R_W + SQRT_BITS;
  localparam int unsigned A_X2       = 2;
  localparam int unsigned A_TAY_END  = A_X2 + 3 * TAY_STEPS;
  localparam int unsigned A_TRIG     = A_TAY_END + 1;
  localparam int unsigned STAGE_MUL  = PIPE_LAST + 1;
  localparam int unsigned STAGE_OUT  = PIPE_LAST + 2;
  localparam int unsigned SH         = 56 - GAUSS_FRAC_BITS;

  typedef struct packed {
    logic [31:0] m;      // normalized mantissa, Q1.31
    logic [31:0] f;      // log2 fraction bits
    logic [5:0]  e;      // UNIFORM_BITS minus leading one position
    logic [60:0] prod;   // scaled log product
    logic [60:0] rem;    // square root remainder
    logic [29:0] root;   // square root, Q.26 radius when done
  } rad_t;

  typedef struct packed {
    logic [31:0] phase;
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] x;
    logic [29:0] x2;
    logic [29:0] ys;
    logic [29:0] yc;
    logic [61:0] yms;
    logic [61:0] ymc;
    logic [30:0] ts;
    logic [30:0] tc;
    logic [30:0] s;
    logic [30:0] c;
  } ang_t;

  typedef struct packed {
    logic [60:0] pc;
    logic [60:0] ps;
    logic        neg_c;
    logic        neg_s;
  } mul_t;

  logic     v_q [0:STAGE_OUT];
  rad_t     rad_q [0:PIPE_LAST];
  ang_t     ang_q [0:PIPE_LAST];
  mul_t     mul_q;
  bmg_out_t res_q;

  // The block never holds a word off.
  assign busy_o         = 1'b0;
  assign result_valid_o = v_q[STAGE_OUT];
  assign result_o       = res_q;

  // Valid bits travel alongside the data, one per stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= STAGE_OUT; k++) v_q[k] <= 1'b0;
    end else begin
      v_q[0] <= start_i & ~busy_o;
      for (int k = 1; k <= STAGE_OUT; k++) v_q[k] <= v_q[k-1];
    end
  end

  // Stage 0: zero substitution, leading one search, normalization, phase.
  logic [UNIFORM_BITS-1:0] u_d;
  logic [4:0]              p_d;
  rad_t                    rad0_d;
  ang_t                    ang0_d;

  always_comb begin
    u_d = word_i.uniform_radius;
    if (u_d == '0) u_d = UNIFORM_BITS'(1);
    p_d = 5'd0;
    for (int i = 0; i < UNIFORM_BITS; i++) begin
      if (u_d[i]) p_d = 5'(i);
    end
    rad0_d      = '0;
    rad0_d.m    = 32'(u_d) << (5'd31 - p_d);
    rad0_d.e    = 6'(UNIFORM_BITS) - 6'(p_d);
    ang0_d      = '0;
    ang0_d.phase = 32'(word_i.uniform_angle) << (32 - UNIFORM_BITS);
  end

  always_ff @(posedge clk_i) begin
    rad_q[0] <= rad0_d;
    ang_q[0] <= ang0_d;
  end

  // Log2 by repeated squaring: each stage yields one fraction bit.
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    logic [63:0] mm_d;
    logic [32:0] tt_d;
    rad_t        nxt_d;
    always_comb begin
      nxt_d = rad_q[g];
      mm_d  = 64'(rad_q[g].m) * 64'(rad_q[g].m);
      tt_d  = mm_d[63:31];
      if (tt_d[32]) begin
        nxt_d.m          = tt_d[32:1];
        nxt_d.f[31 - g]  = 1'b1;
      end else begin
        nxt_d.m = tt_d[31:0];
      end
    end
    always_ff @(posedge clk_i) rad_q[g+1] <= nxt_d;
  end

  // -log2(u) and the multiply by 2 ln 2.
  logic [37:0] l_d;
  rad_t        radl_d;
  always_comb begin
    radl_d      = rad_q[R_L-1];
    l_d         = {rad_q[R_L-1].e, 32'd0} - 38'(rad_q[R_L-1].f);
    radl_d.prod = 61'(l_d[37:8]) * 61'(TWO_LN2_Q30);
  end
  always_ff @(posedge clk_i) rad_q[R_L] <= radl_d;

  // Round to Q.32 and load the square root operand.
  logic [61:0] wsum_d;
  rad_t        radw_d;
  always_comb begin
    radw_d      = rad_q[R_W-1];
    wsum_d      = 62'(rad_q[R_W-1].prod) + (62'd1 << 21);
    radw_d.rem  = 61'({wsum_d[60:22], 20'd0});
    radw_d.root = '0;
  end
  always_ff @(posedge clk_i) rad_q[R_W] <= radw_d;

  // Restoring square root, one root bit per stage from the top.
  for (genvar g = 0; g < SQRT_BITS; g++) begin : g_sqrt
    localparam int unsigned K = SQRT_BITS - 1 - g;
    logic [60:0] trial_d;
    rad_t        nxt_d;
    always_comb begin
      nxt_d   = rad_q[R_W+g];
      trial_d = (61'(rad_q[R_W+g].root) << (K + 1)) | (61'd1 << (2 * K));
      if (rad_q[R_W+g].rem >= trial_d) begin
        nxt_d.rem     = rad_q[R_W+g].rem - trial_d;
        nxt_d.root[K] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) rad_q[R_W+g+1] <= nxt_d;
  end

  // Angle stage 1: fold into the first octant and convert to radians.
  logic [29:0] frac_d;
  logic [29:0] op_d;
  logic [61:0] xp_d;
  ang_t        ang1_d;
  always_comb begin
    ang1_d      = ang_q[0];
    frac_d      = ang_q[0].phase[29:0];
    ang1_d.quad = ang_q[0].phase[31:30];
    ang1_d.swap = (frac_d > 30'(ONE_Q30 >> 1));
    op_d        = ang1_d.swap ? (30'(ONE_Q30) - frac_d) : frac_d;
    xp_d        = 62'(op_d) * 62'(TWO_PI_Q29);
    ang1_d.x    = xp_d[60:31];
  end
  always_ff @(posedge clk_i) ang_q[1] <= ang1_d;

  // Angle stage 2: square of the octant angle, series seeds.
  logic [59:0] x2p_d;
  ang_t        ang2_d;
  always_comb begin
    ang2_d    = ang_q[A_X2-1];
    x2p_d     = 60'(ang_q[A_X2-1].x) * 60'(ang_q[A_X2-1].x);
    ang2_d.x2 = x2p_d[59:30];
    ang2_d.ts = ONE_Q30;
    ang2_d.tc = ONE_Q30;
  end
  always_ff @(posedge clk_i) ang_q[A_X2] <= ang2_d;

  // Horner steps: product, reciprocal multiply, correction and subtract.
  for (genvar g = 0; g < TAY_STEPS; g++) begin : g_tay
    localparam int unsigned KA = A_X2 + 1 + 3 * g;
    logic [60:0] pps_d;
    logic [60:0] ppc_d;
    logic [29:0] qes_d;
    logic [29:0] qec_d;
    logic [29:0] rms_d;
    logic [29:0] rmc_d;
    ang_t        na_d;
    ang_t        nb_d;
    ang_t        nc_d;

    always_comb begin
      na_d    = ang_q[KA-1];
      pps_d   = 61'(ang_q[KA-1].x2) * 61'(ang_q[KA-1].ts);
      ppc_d   = 61'(ang_q[KA-1].x2) * 61'(ang_q[KA-1].tc);
      na_d.ys = pps_d[59:30];
      na_d.yc = ppc_d[59:30];
    end
    always_ff @(posedge clk_i) ang_q[KA] <= na_d;

    always_comb begin
      nb_d     = ang_q[KA];
      nb_d.yms = 62'(ang_q[KA].ys) * 62'(SIN_RECIP[g]);
      nb_d.ymc = 62'(ang_q[KA].yc) * 62'(COS_RECIP[g]);
    end
    always_ff @(posedge clk_i) ang_q[KA+1] <= nb_d;

    always_comb begin
      nc_d  = ang_q[KA+1];
      qes_d = ang_q[KA+1].yms[61:32];
      qec_d = ang_q[KA+1].ymc[61:32];
      rms_d = ang_q[KA+1].ys - 30'(qes_d * 30'(SIN_DIV[g]));
      rmc_d = ang_q[KA+1].yc - 30'(qec_d * 30'(COS_DIV[g]));
      if (rms_d >= 30'(SIN_DIV[g])) qes_d = qes_d + 30'd1;
      if (rmc_d >= 30'(COS_DIV[g])) qec_d = qec_d + 30'd1;
      nc_d.ts = ONE_Q30 - 31'(qes_d);
      nc_d.tc = ONE_Q30 - 31'(qec_d);
    end
    always_ff @(posedge clk_i) ang_q[KA+2] <= nc_d;
  end

  // Finish the sine and undo the octant reflection.
  logic [60:0] sp_d;
  logic [30:0] sv_d;
  ang_t        angt_d;
  always_comb begin
    angt_d = ang_q[A_TRIG-1];
    sp_d   = 61'(ang_q[A_TRIG-1].x) * 61'(ang_q[A_TRIG-1].ts);
    sv_d   = 31'(sp_d[59:30]);
    if (ang_q[A_TRIG-1].swap) begin
      angt_d.s = ang_q[A_TRIG-1].tc;
      angt_d.c = sv_d;
    end else begin
      angt_d.s = sv_d;
      angt_d.c = ang_q[A_TRIG-1].tc;
    end
  end
  always_ff @(posedge clk_i) ang_q[A_TRIG] <= angt_d;

  // Delay line that lines the trig values up with the radius.
  for (genvar k = A_TRIG + 1; k <= PIPE_LAST; k++) begin : g_dly
    always_ff @(posedge clk_i) ang_q[k] <= ang_q[k-1];
  end

  // Quadrant selection and radius multiplies.
  logic [30:0] selc_d;
  logic [30:0] sels_d;
  mul_t        mul_d;
  always_comb begin
    if (ang_q[PIPE_LAST].quad[0]) begin
      selc_d = ang_q[PIPE_LAST].s;
      sels_d = ang_q[PIPE_LAST].c;
    end else begin
      selc_d = ang_q[PIPE_LAST].c;
      sels_d = ang_q[PIPE_LAST].s;
    end
    mul_d.pc    = 61'(rad_q[PIPE_LAST].root) * 61'(selc_d);
    mul_d.ps    = 61'(rad_q[PIPE_LAST].root) * 61'(sels_d);
    mul_d.neg_c = ang_q[PIPE_LAST].quad[0] ^ ang_q[PIPE_LAST].quad[1];
    mul_d.neg_s = ang_q[PIPE_LAST].quad[1];
  end
  always_ff @(posedge clk_i) mul_q <= mul_d;

  // Round the magnitude half up, saturate, then apply the sign.
  function automatic logic [GAUSS_BITS-1:0] scale_out(input logic [60:0] prod,
                                                      input logic neg);
    logic [61:0] sum;
    logic [61:0] mag;
    sum = 62'(prod) + (62'd1 << (SH - 1));
    mag = sum >> SH;
    if (neg) begin
      if (mag > 62'd32768) mag = 62'd32768;
      return GAUSS_BITS'(~mag + 62'd1);
    end
    if (mag > 62'd32767) mag = 62'd32767;
    return GAUSS_BITS'(mag);
  endfunction

  bmg_out_t res_d;
  always_comb begin
    res_d.gauss_cos = scale_out(mul_q.pc, mul_q.neg_c);
    res_d.gauss_sin = scale_out(mul_q.ps, mul_q.neg_s);
  end
  always_ff @(posedge clk_i) res_q <= res_d;

endmodule

>>> dv/tb.sv
// Testbench for the Box-Muller Gaussian pair generator: random and directed words checked in order.
module tb;
  import bmg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIPE_LATENCY = 67;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  bmg_in_t  word_i;
  logic     result_valid_o;
  bmg_out_t result_o;

  box_muller_gaussian_pair u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .word_i         (word_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Free-running 100 MHz clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  bmg_in_t  pending_words[$];   // words waiting to be driven
  bmg_out_t expected_pairs[$];  // predicted Gaussian pairs, oldest first
  int unsigned cycle_count;
  int unsigned error_count;
  bit          sender_hold;     // set by the stimulus to drain the pipeline
  bit          calm_stretch;    // no random gaps while set

  // Integer square root, bit by bit, of a 64-bit value.
  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] probe;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Radius sqrt(-2 ln(u / 2^16)) in Q.26 for nonzero u.
  function automatic logic [63:0] radius_of(input logic [63:0] u);
    int unsigned msb;
    logic [63:0] mant;
    logic [63:0] log_frac;
    logic [63:0] neg_log2;
    logic [63:0] two_ln;
    msb      = 0;
    log_frac = '0;
    while (msb < 63 && (u >> (msb + 1)) != 0) msb++;
    mant = u << (31 - msb);
    for (int i = 0; i < 32; i++) begin
      mant = (mant * mant) >> 31;
      if (mant >= (64'd1 << 32)) begin
        mant = mant >> 1;
        log_frac[31 - i] = 1'b1;
      end
    end
    neg_log2 = (64'(UNIFORM_BITS - msb) << 32) - log_frac;
    two_ln   = ((neg_log2 >> 8) * 64'(TWO_LN2_Q30) + (64'd1 << 21)) >> 22;
    return int_sqrt(two_ln << 20);
  endfunction

  // Horner-form Taylor series in Q.30; the sine variant multiplies by x at the end.
  function automatic logic [63:0] taylor_q30(input logic [63:0] x, input bit is_sin);
    logic [63:0] x_sq;
    logic [63:0] acc;
    logic [63:0] one;
    logic [63:0] divisor;
    one  = 64'(ONE_Q30);
    x_sq = (x * x) >> 30;
    acc  = one;
    for (int i = 0; i < TAY_STEPS; i++) begin
      divisor = is_sin ? 64'(SIN_DIV[i]) : 64'(COS_DIV[i]);
      acc     = one - ((x_sq * acc) >> 30) / divisor;
    end
    return is_sin ? (x * acc) >> 30 : acc;
  endfunction

  // Scale radius times trig value to Q3.12, rounding the magnitude and saturating.
  function automatic logic [15:0] scale_gauss(input logic [63:0] r, input logic [63:0] trig,
                                              input bit neg);
    int unsigned sh;
    logic [63:0] mag;
    sh  = 56 - GAUSS_FRAC_BITS;
    mag = (r * trig + (64'd1 << (sh - 1))) >> sh;
    if (neg) begin
      if (mag > 64'd32768) mag = 64'd32768;
      return 16'(64'h10000 - mag);
    end
    if (mag > 64'd32767) mag = 64'd32767;
    return mag[15:0];
  endfunction

  function automatic bmg_out_t gaussian_pair(input bmg_in_t w);
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] phase;
    logic [63:0] frac;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] c;
    logic [1:0]  quadrant;
    bmg_out_t    res;
    u = 64'(w.uniform_radius);
    // A zero radius sample is taken as the smallest step, saturating the radius.
    if (u == 0) u = 64'd1;
    r        = radius_of(u);
    phase    = 64'(w.uniform_angle) << (32 - UNIFORM_BITS);
    quadrant = phase[31:30];
    frac     = phase & (64'(ONE_Q30) - 1);
    // Past the quadrant midpoint the angle is mirrored and sine and cosine swap.
    if (frac <= (64'd1 << 29)) begin
      x = (frac * 64'(TWO_PI_Q29)) >> 31;
      s = taylor_q30(x, 1'b1);
      c = taylor_q30(x, 1'b0);
    end else begin
      x = ((64'(ONE_Q30) - frac) * 64'(TWO_PI_Q29)) >> 31;
      s = taylor_q30(x, 1'b0);
      c = taylor_q30(x, 1'b1);
    end
    case (quadrant)
      2'd0: begin
        res.gauss_cos = scale_gauss(r, c, 1'b0);
        res.gauss_sin = scale_gauss(r, s, 1'b0);
      end
      2'd1: begin
        res.gauss_cos = scale_gauss(r, s, 1'b1);
        res.gauss_sin = scale_gauss(r, c, 1'b0);
      end
      2'd2: begin
        res.gauss_cos = scale_gauss(r, c, 1'b1);
        res.gauss_sin = scale_gauss(r, s, 1'b1);
      end
      default: begin
        res.gauss_cos = scale_gauss(r, s, 1'b0);
        res.gauss_sin = scale_gauss(r, c, 1'b1);
      end
    endcase
    return res;
  endfunction

  // Driver: presents the next pending word, idling at random with a 15 percent chance
  // unless a calm stretch is running. The prediction is queued when the word is
  // accepted, which is the edge where start is high and busy is low.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      word_i  <= '0;
    end else begin
      if (start_i && !busy_o) begin
        expected_pairs.push_back(gaussian_pair(word_i));
        void'(pending_words.pop_front());
      end
      // Decide what to present next; start_i gets one assignment per edge.
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (pending_words.size() > ((start_i && !busy_o) ? 0 : 0) &&
                   !sender_hold && (calm_stretch || $urandom_range(99) >= 15)) begin
        start_i <= 1'b1;
        word_i  <= pending_words[0];
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every strobed word is compared with the oldest prediction.
  always @(posedge clk_i) begin
    bmg_out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result word, got cos %0d sin %0d", $time,
                 result_o.gauss_cos, result_o.gauss_sin);
        error_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (result_o.gauss_cos !== want.gauss_cos) begin
          $display("%0t: gauss_cos mismatch, expected %0d, actual %0d", $time,
                   want.gauss_cos, result_o.gauss_cos);
          error_count++;
        end
        if (result_o.gauss_sin !== want.gauss_sin) begin
          $display("%0t: gauss_sin mismatch, expected %0d, actual %0d", $time,
                   want.gauss_sin, result_o.gauss_sin);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("box_muller_gaussian_pair test failed");
      $finish;
    end
  end

  function automatic bmg_in_t make_word(input logic [15:0] r, input logic [15:0] a);
    bmg_in_t w;
    w.uniform_radius = r;
    w.uniform_angle  = a;
    return w;
  endfunction

  // Waits until the driver has handed off every queued word.
  task automatic wait_queued();
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] radius_edges[8];
    logic [15:0] angle_edges[10];
    int unsigned pick;
    cycle_count   = 0;
    error_count   = 0;
    sender_hold   = 1'b0;
    calm_stretch  = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words: radius extremes (zero saturates), quadrant and octant
    // boundaries of the angle, and all-ones on every bit.
    radius_edges = '{16'h0000, 16'h0001, 16'h0002, 16'h8000, 16'h7fff, 16'hfffe,
                     16'hffff, 16'h1234};
    angle_edges  = '{16'h0000, 16'h2000, 16'h2001, 16'h4000, 16'h6000, 16'h8000,
                     16'hc000, 16'he000, 16'hffff, 16'h1fff};
    for (int i = 0; i < 8; i++) pending_words.push_back(make_word(radius_edges[i], 16'h1555));
    for (int i = 0; i < 10; i++) pending_words.push_back(make_word(16'h0000, angle_edges[i]));
    pending_words.push_back(make_word(16'hffff, 16'hffff));
    pending_words.push_back(make_word(16'h0001, 16'h4000));
    wait_queued();

    // Hold the sender off until the pipeline has drained completely.
    sender_hold = 1'b1;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    sender_hold = 1'b0;

    // Random words; mostly uniform, some biased to small radius samples, which give
    // the largest radius, some on angle boundaries, and a back-to-back stretch in the middle.
    for (int n = 0; n < 700; n++) begin
      pick = $urandom_range(9);
      if (pick < 2)
        pending_words.push_back(make_word(16'($urandom_range(15)), 16'($urandom)));
      else if (pick == 2)
        pending_words.push_back(make_word(16'($urandom), angle_edges[$urandom_range(9)]));
      else
        pending_words.push_back(make_word(16'($urandom), 16'($urandom)));
      if (n == 300) begin
        wait_queued();
        calm_stretch = 1'b1;
      end
      if (n == 450) begin
        wait_queued();
        calm_stretch = 1'b0;
      end
    end
    wait_queued();
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 10) @(posedge clk_i);

    if (error_count == 0 && expected_pairs.size() == 0) begin
      $display("box_muller_gaussian_pair test passed");
    end else begin
      $display("box_muller_gaussian_pair test failed");
    end
    $finish;
  end

endmodule
